>>> src/mbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbg_pkg
// Shared constants, types and helpers for the maze backtracker generator.
// ----------------------------------------------------------------------------
package mbg_pkg;

    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 16;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CELL_W   = COL_W + ROW_W;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int DEPTH_W  = CELL_W + 1;
    localparam int CCFG_W   = 6;
    localparam int RCFG_W   = 5;

    // opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_OPEN  = 2'd3;

    // directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;

    // one result item
    typedef struct packed {
        logic             passable;
        logic [3:0]       walls;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             finished;
        logic             carved;
    } result_t;

    // neighbour cell index (only meaningful when in range)
    function automatic logic [CELL_W-1:0] nb_cell(input logic [CELL_W-1:0] ci,
                                                  input logic [1:0] d);
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] r;
        c = ci[COL_W-1:0];
        r = ci[CELL_W-1:COL_W];
        case (d)
            DIR_UP:    r = r - 1'b1;
            DIR_RIGHT: c = c + 1'b1;
            DIR_DOWN:  r = r + 1'b1;
            default:   c = c - 1'b1;
        endcase
        return {r, c};
    endfunction

    // neighbour lies inside the used grid
    function automatic logic nb_in(input logic [CELL_W-1:0] ci, input logic [1:0] d,
                                   input logic [CCFG_W-1:0] effc,
                                   input logic [RCFG_W-1:0] effr);
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] r;
        logic             ok;
        c = ci[COL_W-1:0];
        r = ci[CELL_W-1:COL_W];
        case (d)
            DIR_UP:    ok = (r != '0);
            DIR_RIGHT: ok = ((CCFG_W'(c) + 1'b1) < effc);
            DIR_DOWN:  ok = ((RCFG_W'(r) + 1'b1) < effr);
            default:   ok = (c != '0);
        endcase
        return ok;
    endfunction

endpackage

>>> src/maze_backtracker_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_generator
// Depth-first maze carver: cell map and path stack in synchronous RAMs.
// Begin first sweeps all 512 cell entries, then marks and stacks the start cell;
// a step pops dead-end cells, then carves toward dir if that neighbour is free.
// Throughput: one item at a time; a step reads the stack top, its four neighbours, the cell.
// Reset: sync, active low; a clear of the whole cell map follows (no items).
// ----------------------------------------------------------------------------
module maze_backtracker_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cell_col[4:0], cell_row[8:5], dir[10:9], zeros
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // carved[0], finished[1], pos_col[6:2],
                                   // pos_row[10:7], closed_walls[14:11], passable[15]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int CW = mbg_pkg::COL_W;
    localparam int RW = mbg_pkg::ROW_W;
    localparam int XW = mbg_pkg::CELL_W;
    localparam int DW = mbg_pkg::DEPTH_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_BEGW = 4'd2;
    localparam logic [3:0] ST_QRD  = 4'd3;
    localparam logic [3:0] ST_QEV  = 4'd4;
    localparam logic [3:0] ST_STEP = 4'd5;
    localparam logic [3:0] ST_SCAN = 4'd6;
    localparam logic [3:0] ST_RDI  = 4'd7;
    localparam logic [3:0] ST_GOTI = 4'd8;
    localparam logic [3:0] ST_WRJ  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    // cell map: bit4 visited, bits3:0 walls; path stack holds cell indexes
    logic [4:0]    cell_mem [mbg_pkg::CELLS];
    logic [XW-1:0] stk_mem  [mbg_pkg::CELLS];

    logic [3:0]    state_reg, state_next;
    logic          init_reg, init_next;
    logic [DW-1:0] clr_reg, clr_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [2:0]    ncnt_reg, ncnt_next;
    logic [3:0]    free_reg, free_next;
    logic          pin_reg, pin_next;
    logic          taken_reg, taken_next;
    logic [1:0]    op_reg, op_next;
    logic [1:0]    dir_reg, dir_next;
    logic [XW-1:0] cell_reg, cell_next;
    logic [XW-1:0] cur_reg, cur_next;
    logic [mbg_pkg::CCFG_W-1:0] cols_reg, cols_next;
    logic [mbg_pkg::RCFG_W-1:0] rows_reg, rows_next;
    mbg_pkg::result_t pend_reg, pend_next, res_reg, res_next;
    logic          mv_reg, mv_next;

    logic          c_re, c_we, s_re, s_we;
    logic [XW-1:0] c_ra, c_wa, s_ra, s_wa;
    logic [4:0]    c_wd, c_rd;
    logic [XW-1:0] s_wd, s_rd;

    logic [mbg_pkg::CCFG_W-1:0] effc;
    logic [mbg_pkg::RCFG_W-1:0] effr;
    logic [CW-1:0] in_c;
    logic [RW-1:0] in_r;
    logic [XW-1:0] cur, nbj;
    logic          fbit, border;
    logic [3:0]    fvec, nwalls;

    // effective grid size and saturated input cell
    always_comb begin
        effc = (cols_reg == '0) ? 6'd1 :
               (cols_reg > 6'(mbg_pkg::MAX_COLS)) ? 6'(mbg_pkg::MAX_COLS) : cols_reg;
        effr = (rows_reg == '0) ? 5'd1 :
               (rows_reg > 5'(mbg_pkg::MAX_ROWS)) ? 5'(mbg_pkg::MAX_ROWS) : rows_reg;
        in_c = s_tdata[CW-1:0];
        in_r = s_tdata[CW+RW-1:CW];
        if (6'(in_c) >= effc) in_c = CW'(effc - 1'b1);
        if (5'(in_r) >= effr) in_r = RW'(effr - 1'b1);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = res_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        init_next  = init_reg;
        clr_next   = clr_reg;
        depth_next = depth_reg;
        ncnt_next  = ncnt_reg;
        free_next  = free_reg;
        pin_next   = pin_reg;
        taken_next = taken_reg;
        op_next    = op_reg;
        dir_next   = dir_reg;
        cell_next  = cell_reg;
        cur_next   = cur_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        c_re = 1'b0; c_ra = cell_reg;
        c_we = 1'b0; c_wa = cell_reg; c_wd = 5'h0F;
        s_re = 1'b0; s_ra = XW'(depth_reg - 1'b1);
        s_we = 1'b0; s_wa = depth_reg[XW-1:0]; s_wd = cell_reg;
        cur    = (ncnt_reg == 3'd0) ? s_rd : cur_reg;
        nbj    = mbg_pkg::nb_cell(cur_reg, dir_reg);
        fbit   = pin_reg && !c_rd[4];
        fvec   = free_reg;
        nwalls = c_rd[3:0];
        border = 1'b0;

        if (mv_reg && m_tready) mv_next = 1'b0;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                mbg_pkg::REG_COLS: cols_next = cfg_data;
                mbg_pkg::REG_ROWS: rows_next = cfg_data[mbg_pkg::RCFG_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    dir_next  = s_tdata[CW+RW+1:CW+RW];
                    cell_next = {in_r, in_c};
                    case (s_tuser)
                        mbg_pkg::OP_BEGIN: begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        mbg_pkg::OP_STEP: state_next = ST_STEP;
                        default:          state_next = ST_QRD;
                    endcase
                end
            end
            // sweep the whole cell map back to closed, unvisited
            ST_CLR: begin
                c_we     = 1'b1;
                c_wa     = clr_reg[XW-1:0];
                c_wd     = 5'h0F;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == DW'(mbg_pkg::CELLS - 1)) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_BEGW;
                end
            end
            ST_BEGW: begin
                c_we = 1'b1; c_wd = 5'h1F;
                s_we = 1'b1; s_wa = '0;
                depth_next = DW'(1);
                pend_next  = '{passable: 1'b0, walls: 4'hF, row: cell_reg[XW-1:CW],
                               col: cell_reg[CW-1:0], finished: 1'b0, carved: 1'b0};
                state_next = ST_OUT;
            end
            ST_QRD: begin
                c_re = 1'b1;
                state_next = ST_QEV;
            end
            // query or open: evaluate, clear a border wall if asked
            ST_QEV: begin
                case (dir_reg)
                    mbg_pkg::DIR_UP:    border = (cell_reg[XW-1:CW] == '0);
                    mbg_pkg::DIR_RIGHT: border = ((6'(cell_reg[CW-1:0]) + 1'b1) == effc);
                    mbg_pkg::DIR_DOWN:  border = ((5'(cell_reg[XW-1:CW]) + 1'b1) == effr);
                    default:            border = (cell_reg[CW-1:0] == '0);
                endcase
                if (op_reg == mbg_pkg::OP_OPEN && border) begin
                    nwalls = c_rd[3:0] & ~(4'b0001 << dir_reg);
                    c_we = 1'b1;
                    c_wd = {c_rd[4], nwalls};
                end
                pend_next = '{passable: !nwalls[dir_reg], walls: nwalls,
                               row: cell_reg[XW-1:CW], col: cell_reg[CW-1:0],
                               finished: (depth_reg == '0), carved: 1'b0};
                state_next = ST_OUT;
            end
            // fetch top of stack, or report finished
            ST_STEP: begin
                if (depth_reg == '0) begin
                    pend_next  = '{passable: 1'b0, walls: 4'h0, row: '0, col: '0,
                                   finished: 1'b1, carved: 1'b0};
                    state_next = ST_OUT;
                end else begin
                    s_re       = 1'b1;
                    ncnt_next  = '0;
                    free_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            // read the four neighbours, one per cycle, collect free bits
            ST_SCAN: begin
                cur_next = cur;
                if (ncnt_reg != 3'd0) fvec[ncnt_reg[1:0] - 1'b1] = fbit;
                free_next = fvec;
                if (ncnt_reg != 3'd4) begin
                    c_re      = 1'b1;
                    c_ra      = mbg_pkg::nb_cell(cur, ncnt_reg[1:0]);
                    pin_next  = mbg_pkg::nb_in(cur, ncnt_reg[1:0], effc, effr);
                    ncnt_next = ncnt_reg + 1'b1;
                end else if (fvec == '0) begin
                    depth_next = depth_reg - 1'b1;
                    state_next = ST_STEP;
                end else begin
                    taken_next = fvec[dir_reg];
                    state_next = ST_RDI;
                end
            end
            ST_RDI: begin
                c_re = 1'b1; c_ra = cur_reg;
                state_next = ST_GOTI;
            end
            ST_GOTI: begin
                if (taken_reg) begin
                    c_we = 1'b1; c_wa = cur_reg;
                    c_wd = {c_rd[4], c_rd[3:0] & ~(4'b0001 << dir_reg)};
                    c_re = 1'b1; c_ra = nbj;
                    state_next = ST_WRJ;
                end else begin
                    pend_next  = '{passable: 1'b0, walls: c_rd[3:0], row: cur_reg[XW-1:CW],
                                   col: cur_reg[CW-1:0], finished: 1'b0, carved: 1'b0};
                    state_next = ST_OUT;
                end
            end
            // open the far side, mark and push the neighbour
            ST_WRJ: begin
                nwalls = c_rd[3:0] & ~(4'b0001 << (dir_reg + 2'd2));
                c_we = 1'b1; c_wa = nbj; c_wd = {1'b1, nwalls};
                s_we = 1'b1; s_wd = nbj;
                depth_next = depth_reg + 1'b1;
                pend_next  = '{passable: 1'b0, walls: nwalls, row: nbj[XW-1:CW],
                               col: nbj[CW-1:0], finished: 1'b0, carved: 1'b1};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    res_next   = pend_reg;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // cell map RAM
    always_ff @(posedge aclk) begin
        if (c_we) cell_mem[c_wa] <= c_wd;
        if (c_re) c_rd <= cell_mem[c_ra];
    end

    // path stack RAM
    always_ff @(posedge aclk) begin
        if (s_we) stk_mem[s_wa] <= s_wd;
        if (s_re) s_rd <= stk_mem[s_ra];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            depth_reg <= '0;
            ncnt_reg  <= '0;
            cols_reg  <= 6'd20;
            rows_reg  <= 5'd10;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            depth_reg <= depth_next;
            ncnt_reg  <= ncnt_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        free_reg  <= free_next;
        pin_reg   <= pin_next;
        taken_reg <= taken_next;
        op_reg    <= op_next;
        dir_reg   <= dir_next;
        cell_reg  <= cell_next;
        cur_reg   <= cur_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
    end

    // checks
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(mbg_pkg::CELLS))
        else $error("stack depth beyond capacity");
    a_begin_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BEGW |=> depth_reg == DW'(1))
        else $error("begin did not leave one stacked cell");
    a_carve_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("carved and finished together");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRJ |=> depth_reg == $past(depth_reg) + 1'b1)
        else $error("carve did not push");

endmodule
